// ===== rtl/core/atw_pkg.sv =====
// Shared constants and types of the affine texture address walker.
// No dependencies; imported by every module of the block.
`default_nettype none

package atw_pkg;

  // Screen raster size
  localparam int SCREEN_COLS = 640;
  localparam int SCREEN_ROWS = 480;

  localparam int COORD_W = 32;
  localparam int TEX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 9;
  localparam int DIV_W   = 11;

  localparam logic [DIV_W-1:0] COLS_DIV = DIV_W'(SCREEN_COLS);
  localparam logic [DIV_W-1:0] ROWS_DIV = DIV_W'(SCREEN_ROWS);

  // floor(2^32 / divisor); the estimate it gives is low by at most one
  localparam logic [COORD_W-1:0] COL_RECIP = 32'(64'h1_0000_0000 / 64'(SCREEN_COLS));
  localparam logic [COORD_W-1:0] ROW_RECIP = 32'(64'h1_0000_0000 / 64'(SCREEN_ROWS));

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_ROWS - 1);

  // Stream packing
  localparam int IN_TDATA_W   = 6 * COORD_W;
  localparam int OUT_FIELDS_W = 2 * TEX_W + COL_W + ROW_W;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_COL_LSB  = 2 * TEX_W;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic start;
    logic tick;
  } in_ctrl_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             eol;
    logic             eof;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/core/atw_step_div.sv =====
// One step divider lane: (far - near) / divisor, truncated toward zero.
// Reciprocal multiply with a single correction, three stages plus result reg.
// Depends on atw_pkg.
`default_nettype none

module atw_step_div import atw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               sel_row_i,  // 0: divide by columns, 1: by rows
  input  wire logic [COORD_W-1:0] far_i,
  input  wire logic [COORD_W-1:0] near_i,
  output      logic               busy_o,
  output      logic [COORD_W-1:0] step_o
);

  logic [COORD_W:0]   diff;
  logic [COORD_W:0]   mag_full;

  logic               v1_q, v2_q, v3_q;
  logic               neg1_q, neg2_q, neg3_q;
  logic               row1_q, row2_q;
  logic [COORD_W-1:0] mag1_q, mag2_q;
  logic [COORD_W-1:0] q2_q, q3_q;
  logic               fix3_q;

  logic [COORD_W-1:0]         recip;
  logic [2*COORD_W-1:0]       prod;
  logic [DIV_W-1:0]           divisor;
  logic [COORD_W+DIV_W-1:0]   back;
  logic [COORD_W:0]           rem;
  logic                       fix_d;
  logic [COORD_W-1:0]         qf;
  logic [COORD_W-1:0]         step_d;

  // exact 33-bit difference; magnitude always fits 32 bits
  assign diff     = {far_i[COORD_W-1], far_i} - {near_i[COORD_W-1], near_i};
  assign mag_full = diff[COORD_W] ? (~diff + 1'b1) : diff;

  assign recip   = row1_q ? ROW_RECIP : COL_RECIP;
  assign prod    = 64'(mag1_q) * 64'(recip);

  assign divisor = row2_q ? ROWS_DIV : COLS_DIV;
  assign back    = (COORD_W+DIV_W)'(q2_q) * (COORD_W+DIV_W)'(divisor);
  assign rem     = {1'b0, mag2_q} - back[COORD_W:0];
  assign fix_d   = (rem >= {{(COORD_W+1-DIV_W){1'b0}}, divisor});

  assign qf      = q3_q + COORD_W'(fix3_q);
  assign step_d  = neg3_q ? (~qf + 1'b1) : qf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      step_o <= '0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        step_o <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg1_q <= diff[COORD_W];
      mag1_q <= mag_full[COORD_W-1:0];
      row1_q <= sel_row_i;
    end
    if (v1_q) begin
      neg2_q <= neg1_q;
      mag2_q <= mag1_q;
      row2_q <= row1_q;
      q2_q   <= prod[2*COORD_W-1:COORD_W];
    end
    if (v2_q) begin
      neg3_q <= neg2_q;
      q3_q   <= q2_q;
      fix3_q <= fix_d;
    end
  end

  assign busy_o = v1_q | v2_q | v3_q;

endmodule

`default_nettype wire

// ===== rtl/core/atw_raster.sv =====
// Raster walker: column/row counters and the two texture walking sums.
// Produces one pixel result per tick while a frame runs. Depends on atw_pkg.
`default_nettype none

module atw_raster import atw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire in_ctrl_t           ctrl_i,
  input  wire logic [COORD_W-1:0] origin_x_i,
  input  wire logic [COORD_W-1:0] origin_y_i,
  input  wire logic [COORD_W-1:0] step_xc_i,
  input  wire logic [COORD_W-1:0] step_yc_i,
  input  wire logic [COORD_W-1:0] step_xr_i,
  input  wire logic [COORD_W-1:0] step_yr_i,
  output      logic               res_valid_o,
  output      pix_t               res_o
);

  logic [COORD_W-1:0] line_x_q, line_x_d;
  logic [COORD_W-1:0] line_y_q, line_y_d;
  logic [COORD_W-1:0] walk_x_q, walk_x_d;
  logic [COORD_W-1:0] walk_y_q, walk_y_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               active_q, active_d;
  logic               eol, eof;

  assign eol = (col_q == COL_LAST);
  assign eof = eol && (row_q == ROW_LAST);

  assign res_valid_o = ctrl_i.tick && active_q;

  always_comb begin
    res_o.tex_u = walk_x_q[23:16];
    res_o.tex_v = walk_y_q[23:16];
    res_o.col   = col_q;
    res_o.row   = row_q;
    res_o.eol   = eol;
    res_o.eof   = eof;
  end

  always_comb begin
    line_x_d = line_x_q;
    line_y_d = line_y_q;
    walk_x_d = walk_x_q;
    walk_y_d = walk_y_q;
    col_d    = col_q;
    row_d    = row_q;
    active_d = active_q;
    if (ctrl_i.start) begin
      // a start abandons any frame in progress
      line_x_d = origin_x_i;
      line_y_d = origin_y_i;
      walk_x_d = origin_x_i;
      walk_y_d = origin_y_i;
      col_d    = '0;
      row_d    = '0;
      active_d = 1'b1;
    end else if (res_valid_o) begin
      if (eol) begin
        line_x_d = line_x_q + step_xr_i;
        line_y_d = line_y_q + step_yr_i;
        walk_x_d = line_x_d;
        walk_y_d = line_y_d;
        col_d    = '0;
        row_d    = row_q + 1'b1;
        active_d = !eof;
      end else begin
        walk_x_d = walk_x_q + step_xc_i;
        walk_y_d = walk_y_q + step_yc_i;
        col_d    = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_x_q <= '0;
      line_y_q <= '0;
      walk_x_q <= '0;
      walk_y_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
    end else begin
      line_x_q <= line_x_d;
      line_y_q <= line_y_d;
      walk_x_q <= walk_x_d;
      walk_y_q <= walk_y_d;
      col_q    <= col_d;
      row_q    <= row_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atw_out_reg.sv =====
// Output register stage for pixel results; takes a new beat whenever it is
// empty or its current beat leaves in the same cycle. Depends on atw_pkg.
`default_nettype none

module atw_out_reg import atw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  wire pix_t res_i,
  input  wire logic m_ready_i,
  output      logic ready_o,
  output      logic m_valid_o,
  output      pix_t res_o
);

  logic valid_q;

  assign ready_o   = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_o <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/affine_texture_address_walker_unit.sv =====
// Affine texture address walker, top level (rotozoom texture mapping).
// Depends on atw_pkg, atw_step_div, atw_raster, atw_out_reg.
`default_nettype none

// A start beat (tuser = 0) loads three 16.16 texture-space corners and begins
// a 640x480 raster; each following pixel tick (tuser = 1) returns the wrapped
// 8-bit texel address, the screen position, tlast at end of line and tuser at
// end of frame. One pixel per clock is sustained while the result side takes every
// beat; the result sits in a one-beat registered output stage, and while that
// beat waits unaccepted s_axis_tready is low.
// After a start beat s_axis_tready stays low while the four step dividers
// (reciprocal multiply, remainder check, sign fix) finish. Ticks outside a
// frame give no result.

module affine_texture_address_walker_unit import atw_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  // origin_x, origin_y, right_x, right_y, bottom_x, bottom_y
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic                   s_axis_tuser,
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tex_u, tex_v, pixel_col, pixel_row, zero fill
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // end_of_line
  output      logic                   m_axis_tlast,
  // end_of_frame
  output      logic                   m_axis_tuser
);

  logic [COORD_W-1:0] origin_x, origin_y, right_x, right_y, bottom_x, bottom_y;
  logic [COORD_W-1:0] step_xc, step_yc, step_xr, step_yr;
  logic [3:0]         busy;
  cmd_e               cmd;
  logic               in_beat;
  in_ctrl_t           ctrl;
  logic               res_valid;
  pix_t               res, res_out;
  logic               out_ready;

  assign origin_x = s_axis_tdata[0*COORD_W +: COORD_W];
  assign origin_y = s_axis_tdata[1*COORD_W +: COORD_W];
  assign right_x  = s_axis_tdata[2*COORD_W +: COORD_W];
  assign right_y  = s_axis_tdata[3*COORD_W +: COORD_W];
  assign bottom_x = s_axis_tdata[4*COORD_W +: COORD_W];
  assign bottom_y = s_axis_tdata[5*COORD_W +: COORD_W];

  assign cmd           = cmd_e'(s_axis_tuser);
  assign s_axis_tready = !(|busy) && out_ready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign ctrl.start    = in_beat && (cmd == CMD_START);
  assign ctrl.tick     = in_beat && (cmd == CMD_TICK);

  atw_step_div u_div_xc (
    .clk_i, .rst_ni, .start_i(ctrl.start), .sel_row_i(1'b0),
    .far_i(right_x), .near_i(origin_x), .busy_o(busy[0]), .step_o(step_xc)
  );
  atw_step_div u_div_yc (
    .clk_i, .rst_ni, .start_i(ctrl.start), .sel_row_i(1'b0),
    .far_i(right_y), .near_i(origin_y), .busy_o(busy[1]), .step_o(step_yc)
  );
  atw_step_div u_div_xr (
    .clk_i, .rst_ni, .start_i(ctrl.start), .sel_row_i(1'b1),
    .far_i(bottom_x), .near_i(origin_x), .busy_o(busy[2]), .step_o(step_xr)
  );
  atw_step_div u_div_yr (
    .clk_i, .rst_ni, .start_i(ctrl.start), .sel_row_i(1'b1),
    .far_i(bottom_y), .near_i(origin_y), .busy_o(busy[3]), .step_o(step_yr)
  );

  atw_raster u_raster (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .origin_x_i(origin_x), .origin_y_i(origin_y),
    .step_xc_i(step_xc), .step_yc_i(step_yc),
    .step_xr_i(step_xr), .step_yr_i(step_yr),
    .res_valid_o(res_valid), .res_o(res)
  );

  atw_out_reg u_out (
    .clk_i, .rst_ni, .res_valid_i(res_valid), .res_i(res),
    .m_ready_i(m_axis_tready), .ready_o(out_ready),
    .m_valid_o(m_axis_tvalid), .res_o(res_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                         res_out.row, res_out.col, res_out.tex_v, res_out.tex_u};
  assign m_axis_tlast = res_out.eol;
  assign m_axis_tuser = res_out.eof;

endmodule

`default_nettype wire

// ===== rtl/core/atw_checker.sv =====
// Port-level checker for the texture address walker, bound to the top level.
// Depends on atw_pkg and affine_texture_address_walker_unit.
`default_nettype none

module atw_checker import atw_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   m_axis_tlast,
  input wire logic                   m_axis_tuser
);

  logic             start_beat, tick_beat;
  logic [COL_W-1:0] out_col;

  assign start_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START);
  assign tick_beat  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK);
  assign out_col    = m_axis_tdata[OUT_COL_LSB +: COL_W];

  // steps are not ready the cycle after a start
  a_hold_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_beat |=> !s_axis_tready)
    else $error("input taken while step dividers busy");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("end of frame without end of line");

  a_eol_at_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (out_col == COL_LAST)))
    else $error("end of line does not match last column");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(tick_beat))
    else $error("result beat without a pixel tick");

  a_out_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

endmodule

bind affine_texture_address_walker_unit atw_checker u_atw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
